/* rtl/ospa_pkg.sv */
// Package with shared constants, codes and controller/datapath interface types of the slot pool.
`default_nettype none

package ospa_pkg;

	localparam int DEF_POOL_SLOTS = 32;
	localparam int OP_W = 2;
	localparam int SLOT_W = 5;
	localparam int VALUE_W = 32;
	localparam int STATUS_W = 2;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W = $clog2(MAX_RESULTS);
	localparam int TDATA_W = 40;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE = 2'd1,
		OP_LIST = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK = 2'd0,
		STS_POOL_EMPTY = 2'd1,
		STS_NOT_ACTIVE = 2'd2,
		STS_LIST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		EMIT_ALLOC,
		EMIT_FREED,
		EMIT_NOT_ACTIVE,
		EMIT_POOL_EMPTY,
		EMIT_LIST_EMPTY,
		EMIT_LIST
	} emit_kind_t;

	typedef enum logic [1:0] {
		RD_INPUT,
		RD_CUR,
		RD_NEXT
	} rd_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC_POP,
		ST_ALLOC_APPEND,
		ST_FREE_WALK,
		ST_FREE_PUSH,
		ST_LIST_WALK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		rd_sel_t rd_sel;
		logic walk_start;
		logic walk_step;
		logic alloc_pop;
		logic alloc_append;
		logic unlink;
		logic push;
		logic emit;
		emit_kind_t kind;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] in_op;
		logic free_empty;
		logic active_empty;
		logic cur_nil;
		logic cur_match;
		logic list_fin;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

/* rtl/ospa_datapath.sv */
// Datapath of the slot pool: link and value memories, list pointers, walk registers and result register.
`default_nettype none

module ospa_datapath
	import ospa_pkg::*;
#(
	parameter int POOL_SLOTS = DEF_POOL_SLOTS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire dp_cmd_t cmd,
	output dp_sts_t sts,
	input wire logic [TDATA_W-1:0] in_data,
	output logic out_valid,
	input wire logic out_ready,
	output logic [TDATA_W-1:0] out_data,
	output logic out_last
);

	localparam int IDX_W = $clog2(POOL_SLOTS);
	localparam int LINK_W = $clog2(POOL_SLOTS + 1);
	localparam int CMP_W = (LINK_W > SLOT_W) ? LINK_W : SLOT_W;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SLOTS);

	logic [LINK_W-1:0] link_mem [POOL_SLOTS];
	logic [VALUE_W-1:0] val_mem [POOL_SLOTS];
	logic [POOL_SLOTS-1:0] link_vld_q;

	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] active_head_q;
	logic [LINK_W-1:0] active_tail_q;
	logic [LINK_W-1:0] cur_q;
	logic [LINK_W-1:0] prev_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SLOT_W-1:0] want_q;
	logic [VALUE_W-1:0] val_q;

	logic [LINK_W-1:0] link_rd_q;
	logic link_hit_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [VALUE_W-1:0] val_rd_q;

	logic out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [VALUE_W-1:0] out_value_q;
	logic out_last_q;

	logic [OP_W-1:0] in_op;
	logic [LINK_W-1:0] raddr;
	logic [IDX_W-1:0] ridx;
	logic [LINK_W-1:0] rd_next;
	logic link_we;
	logic [LINK_W-1:0] link_waddr;
	logic [LINK_W-1:0] link_wdata;
	logic [IDX_W-1:0] link_widx;
	logic rd_nil;
	logic list_fin;
	logic out_free;
	logic [STATUS_W-1:0] res_status;
	logic [SLOT_W-1:0] res_slot;
	logic [VALUE_W-1:0] res_value;
	logic res_last;

	assign in_op = in_data[OP_W-1:0];

	always_comb begin
		unique case (cmd.rd_sel)
			RD_INPUT: raddr = (in_op == OP_ALLOC) ? free_head_q : active_head_q;
			RD_CUR: raddr = cur_q;
			RD_NEXT: raddr = rd_next;
			default: raddr = cur_q;
		endcase
	end

	assign ridx = raddr[IDX_W-1:0];

	// An entry never written reads as its reset link, which is always the next slot number.
	assign rd_next = link_hit_q ? link_rd_q : (LINK_W'(rd_idx_q) + LINK_W'(1));
	assign rd_nil = (rd_next == NIL);
	assign list_fin = rd_nil || (cnt_q == CNT_W'(MAX_RESULTS - 1));
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		link_we = 1'b0;
		link_waddr = cur_q;
		link_wdata = NIL;
		if (cmd.alloc_pop) begin
			link_we = 1'b1;
			link_waddr = free_head_q;
			link_wdata = NIL;
		end else if (cmd.alloc_append) begin
			link_we = (active_tail_q != NIL);
			link_waddr = active_tail_q;
			link_wdata = cur_q;
		end else if (cmd.unlink) begin
			link_we = (prev_q != NIL);
			link_waddr = prev_q;
			link_wdata = rd_next;
		end else if (cmd.push) begin
			link_we = 1'b1;
			link_waddr = cur_q;
			link_wdata = free_head_q;
		end
	end

	assign link_widx = link_waddr[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_widx] <= link_wdata;
		end
		link_rd_q <= link_mem[ridx];
		link_hit_q <= link_vld_q[ridx];
		rd_idx_q <= ridx;
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc_pop) begin
			val_mem[free_head_q[IDX_W-1:0]] <= val_q;
		end
		val_rd_q <= val_mem[ridx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
			free_head_q <= '0;
			active_head_q <= NIL;
			active_tail_q <= NIL;
		end else begin
			if (link_we) begin
				link_vld_q[link_widx] <= 1'b1;
			end
			if (cmd.alloc_pop) begin
				free_head_q <= rd_next;
			end
			if (cmd.alloc_append) begin
				if (active_tail_q == NIL) begin
					active_head_q <= cur_q;
				end
				active_tail_q <= cur_q;
			end
			if (cmd.unlink) begin
				if (prev_q == NIL) begin
					active_head_q <= rd_next;
				end
				if (active_tail_q == cur_q) begin
					active_tail_q <= prev_q;
				end
			end
			if (cmd.push) begin
				free_head_q <= cur_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			want_q <= in_data[OP_W +: SLOT_W];
			val_q <= in_data[OP_W + SLOT_W +: VALUE_W];
		end
		if (cmd.capture && (in_op == OP_ALLOC)) begin
			cur_q <= free_head_q;
		end else if (cmd.walk_start) begin
			cur_q <= active_head_q;
		end else if (cmd.walk_step) begin
			cur_q <= rd_next;
		end
		if (cmd.walk_start) begin
			prev_q <= NIL;
			cnt_q <= '0;
		end else if (cmd.walk_step) begin
			prev_q <= cur_q;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_comb begin
		res_status = STS_OK;
		res_slot = '0;
		res_value = '0;
		res_last = 1'b1;
		unique case (cmd.kind)
			EMIT_ALLOC: begin
				res_slot = SLOT_W'(cur_q);
				res_value = val_q;
			end
			EMIT_FREED: begin
				res_slot = SLOT_W'(cur_q);
			end
			EMIT_NOT_ACTIVE: begin
				res_status = STS_NOT_ACTIVE;
				res_slot = want_q;
			end
			EMIT_POOL_EMPTY: begin
				res_status = STS_POOL_EMPTY;
			end
			EMIT_LIST_EMPTY: begin
				res_status = STS_LIST_EMPTY;
			end
			EMIT_LIST: begin
				res_slot = SLOT_W'(cur_q);
				res_value = val_rd_q;
				res_last = list_fin;
			end
			default: begin
				res_status = STS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= res_status;
			out_slot_q <= res_slot;
			out_value_q <= res_value;
			out_last_q <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = TDATA_W'({out_value_q, out_slot_q, out_status_q});
	assign out_last = out_last_q;

	assign sts.in_op = in_op;
	assign sts.free_empty = (free_head_q == NIL);
	assign sts.active_empty = (active_head_q == NIL);
	assign sts.cur_nil = (cur_q == NIL);
	assign sts.cur_match = (CMP_W'(cur_q) == CMP_W'(want_q));
	assign sts.list_fin = list_fin;
	assign sts.out_free = out_free;

	a_head_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(active_head_q == NIL) == (active_tail_q == NIL))
		else $error("active head and tail disagree on an empty list");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q <= NIL) && (active_head_q <= NIL) && (active_tail_q <= NIL))
		else $error("list pointer beyond the pool");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result loaded over an item not yet taken");

endmodule

`default_nettype wire

/* rtl/ospa_controller.sv */
// Controller state machine of the slot pool: sequences allocate, free walk and list walk.
`default_nettype none

module ospa_controller
	import ospa_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output dp_cmd_t cmd,
	input wire dp_sts_t sts
);

	state_t state_q;
	state_t state_d;
	emit_kind_t kind_q;
	emit_kind_t kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= EMIT_ALLOC;
		end else begin
			state_q <= state_d;
			kind_q <= kind_d;
		end
	end

	always_comb begin
		state_d = state_q;
		kind_d = kind_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.rd_sel = RD_CUR;
		cmd.kind = kind_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.rd_sel = RD_INPUT;
				if (in_valid) begin
					unique case (sts.in_op)
						OP_ALLOC: begin
							cmd.capture = 1'b1;
							if (sts.free_empty) begin
								kind_d = EMIT_POOL_EMPTY;
								state_d = ST_EMIT;
							end else begin
								state_d = ST_ALLOC_POP;
							end
						end
						OP_FREE: begin
							cmd.capture = 1'b1;
							cmd.walk_start = 1'b1;
							if (sts.active_empty) begin
								kind_d = EMIT_NOT_ACTIVE;
								state_d = ST_EMIT;
							end else begin
								state_d = ST_FREE_WALK;
							end
						end
						OP_LIST: begin
							cmd.capture = 1'b1;
							cmd.walk_start = 1'b1;
							if (sts.active_empty) begin
								kind_d = EMIT_LIST_EMPTY;
								state_d = ST_EMIT;
							end else begin
								state_d = ST_LIST_WALK;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_ALLOC_POP: begin
				cmd.alloc_pop = 1'b1;
				state_d = ST_ALLOC_APPEND;
			end
			ST_ALLOC_APPEND: begin
				cmd.alloc_append = 1'b1;
				kind_d = EMIT_ALLOC;
				state_d = ST_EMIT;
			end
			ST_FREE_WALK: begin
				priority if (sts.cur_nil) begin
					kind_d = EMIT_NOT_ACTIVE;
					state_d = ST_EMIT;
				end else if (sts.cur_match) begin
					cmd.unlink = 1'b1;
					state_d = ST_FREE_PUSH;
				end else begin
					cmd.walk_step = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end
			end
			ST_FREE_PUSH: begin
				cmd.push = 1'b1;
				kind_d = EMIT_FREED;
				state_d = ST_EMIT;
			end
			ST_LIST_WALK: begin
				cmd.kind = EMIT_LIST;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.list_fin) begin
						state_d = ST_IDLE;
					end else begin
						cmd.walk_step = 1'b1;
						cmd.rd_sel = RD_NEXT;
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && sts.out_free) |=> (state_q == ST_IDLE))
		else $error("single result sent but controller did not return to idle");

	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (state_q == ST_IDLE && in_valid))
		else $error("item captured outside an accept");

	a_push_after_unlink: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> $past(cmd.unlink))
		else $error("slot pushed on the free list without being unlinked");

endmodule

`default_nettype wire

/* rtl/ordered_slot_pool_allocator.sv */
// Top level of the ordered slot pool allocator: stream ports, controller and datapath.
`default_nettype none

// Slots are kept on a free stack and an ordered active list that share one link memory with a
// registered read port. One item is worked on at a time; a new item is accepted as soon as the
// controller is back in idle, even while the last result still waits in the output register.
// Allocate steps through accept, pop, append and result. Free walks the active list one slot per
// cycle from the head up to the freed slot, or over every active slot on a miss. List sends one
// result per cycle while the output is not stalled, at most 32 results. The walk rate is set by
// the single link memory read per cycle. Errors give a single result. No clearing pass is needed
// after reset.
module ordered_slot_pool_allocator
	import ospa_pkg::*;
#(
	parameter int POOL_SLOTS = DEF_POOL_SLOTS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// operation[1:0], slot_number[6:2], initial_value[38:7], zero[39]
	input wire logic [TDATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// status[1:0], result_slot[6:2], result_value[38:7], zero[39]
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic m_axis_tlast
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	ospa_controller u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.cmd(cmd),
		.sts(sts)
	);

	ospa_datapath #(
		.POOL_SLOTS(POOL_SLOTS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_data(s_axis_tdata),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data(m_axis_tdata),
		.out_last(m_axis_tlast)
	);

endmodule

`default_nettype wire
